// ===== rtl/esd_pkg.sv =====
`default_nettype none
package esd_pkg;

  localparam int CHAR_W = 16;
  localparam int BYTE_W = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_B = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LOWER_F = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LOWER_N = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOWER_R = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOWER_V = 8'h76;
  localparam logic [BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT_7 = 8'h37;
  localparam logic [BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;

  localparam logic [BYTE_W-1:0] CODE_BEL = 8'd7;
  localparam logic [BYTE_W-1:0] CODE_BS = 8'd8;
  localparam logic [BYTE_W-1:0] CODE_HT = 8'd9;
  localparam logic [BYTE_W-1:0] CODE_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_VT = 8'd11;
  localparam logic [BYTE_W-1:0] CODE_FF = 8'd12;
  localparam logic [BYTE_W-1:0] CODE_CR = 8'd13;

  localparam logic [1:0] WARN_NONE = 2'd0;
  localparam logic [1:0] WARN_ALERT = 2'd1;
  localparam logic [1:0] WARN_HEX = 2'd2;

  typedef enum logic [4:0] {
    MODE_PLAIN     = 5'b00001,
    MODE_ESC       = 5'b00010,
    MODE_HEX_FIRST = 5'b00100,
    MODE_HEX_RUN   = 5'b01000,
    MODE_OCT_RUN   = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] value;
    logic [1:0]        warn;
    logic              dangling;
    logic              last;
  } res_t;

  // One queue entry: all results caused by one input transaction.
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [CHAR_W-1:0] widen(input logic [BYTE_W-1:0] b);
    return {{(CHAR_W-BYTE_W){1'b0}}, b};
  endfunction

  // Bit 4 set when b is a hex digit; low nibble is its value.
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= CH_LOWER_A && b <= CH_LOWER_F) ||
                 (b >= CH_UPPER_A && b <= CH_UPPER_F)) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic is_oct(input logic [BYTE_W-1:0] b);
    return (b >= CH_DIGIT_0) && (b <= CH_DIGIT_7);
  endfunction

  function automatic logic [BYTE_W-1:0] esc_value(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    unique case (b)
      CH_LOWER_A: v = CODE_BEL;
      CH_LOWER_V: v = CODE_VT;
      CH_LOWER_N: v = CODE_LF;
      CH_LOWER_T: v = CODE_HT;
      CH_LOWER_R: v = CODE_CR;
      CH_LOWER_B: v = CODE_BS;
      CH_LOWER_F: v = CODE_FF;
      default:    v = b;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/esd_front.sv =====
`default_nettype none
module esd_front import esd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_eos,
  output logic                   push,
  output cmd_t                   cmd
);

  mode_t             mode_r, mode_nxt;
  logic [CHAR_W-1:0] acc_r, acc_nxt;
  logic [4:0]        hd;
  logic              plain_emit;
  mode_t             plain_mode;
  logic [1:0]        nres;
  res_t              r0, r1;

  always_comb begin
    hd = hex_digit(in_byte);
    plain_emit = (in_byte != CH_BACKSLASH);
    plain_mode = plain_emit ? MODE_PLAIN : MODE_ESC;
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    nres = 2'd0;
    r0 = '{value: widen(in_byte), warn: WARN_NONE, dangling: 1'b0, last: 1'b0};
    r1 = '{value: widen(in_byte), warn: WARN_NONE, dangling: 1'b0, last: 1'b1};
    if (in_eos) begin
      // Flush whatever escape is pending.
      mode_nxt = MODE_PLAIN;
      acc_nxt = '0;
      unique case (mode_r)
        MODE_ESC: begin
          r0.value = widen(CH_BACKSLASH);
          r0.dangling = 1'b1;
          nres = 2'd1;
        end
        MODE_HEX_FIRST: begin
          r0.value = widen(CH_LOWER_X);
          r0.warn = WARN_HEX;
          nres = 2'd1;
        end
        MODE_HEX_RUN: begin
          r0.value = acc_r;
          r0.warn = WARN_HEX;
          nres = 2'd1;
        end
        MODE_OCT_RUN: begin
          r0.value = acc_r;
          nres = 2'd1;
        end
        default: nres = 2'd0;
      endcase
    end else begin
      unique case (mode_r)
        MODE_ESC: begin
          if (in_byte == CH_LOWER_X) begin
            mode_nxt = MODE_HEX_FIRST;
            acc_nxt = '0;
          end else if (is_oct(in_byte)) begin
            mode_nxt = MODE_OCT_RUN;
            acc_nxt = {{(CHAR_W-3){1'b0}}, in_byte[2:0]};
          end else begin
            mode_nxt = MODE_PLAIN;
            r0.value = widen(esc_value(in_byte));
            r0.warn = (in_byte == CH_LOWER_A) ? WARN_ALERT : WARN_NONE;
            nres = 2'd1;
          end
        end
        MODE_HEX_FIRST, MODE_HEX_RUN: begin
          if (hd[4]) begin
            acc_nxt = {acc_r[CHAR_W-5:0], hd[3:0]};
            mode_nxt = MODE_HEX_RUN;
          end else begin
            // Close the run, then reprocess the byte in plain mode.
            r0.value = (mode_r == MODE_HEX_FIRST) ? widen(CH_LOWER_X) : acc_r;
            r0.warn = WARN_HEX;
            acc_nxt = '0;
            mode_nxt = plain_mode;
            nres = plain_emit ? 2'd2 : 2'd1;
          end
        end
        MODE_OCT_RUN: begin
          if (is_oct(in_byte)) begin
            acc_nxt = {acc_r[CHAR_W-4:0], in_byte[2:0]};
          end else begin
            r0.value = acc_r;
            acc_nxt = '0;
            mode_nxt = plain_mode;
            nres = plain_emit ? 2'd2 : 2'd1;
          end
        end
        default: begin
          mode_nxt = plain_mode;
          nres = plain_emit ? 2'd1 : 2'd0;
        end
      endcase
    end
    r0.last = (nres == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign push = accept && (nres != 2'd0);
  assign cmd = '{first: r0, second: r1, two: (nres == 2'd2)};

endmodule
`default_nettype wire

// ===== rtl/esd_queue.sv =====
`default_nettype none
module esd_queue import esd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output qstat_t    stat
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] count_r;

  assign stat.full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= QPTR_W'(wr_r + 1'b1);
      end
      if (pop) begin
        rd_r <= QPTR_W'(rd_r + 1'b1);
      end
      case ({push, pop})
        2'b10:   count_r <= QCNT_W'(count_r + 1'b1);
        2'b01:   count_r <= QCNT_W'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("queue read while empty");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.empty || stat.full) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== rtl/esd_back.sv =====
`default_nettype none
module esd_back import esd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cmd_t   head,
  input  wire qstat_t stat,
  output logic        pop,
  input  wire logic   out_ready,
  output logic        out_valid,
  output res_t        out_res
);

  logic out_valid_r;
  res_t out_res_r;
  logic sel_r, sel_nxt;
  logic load;

  assign load = !stat.empty && (!out_valid_r || out_ready);
  assign pop = load && (!head.two || sel_r);

  always_comb begin
    sel_nxt = sel_r;
    if (load) begin
      sel_nxt = head.two && !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= sel_r ? head.second : head.first;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res = out_res_r;

endmodule
`default_nettype wire

// ===== rtl/escape_sequence_decoder_core.sv =====
`default_nettype none
// Backslash escape decoder for a byte stream. One byte enters per cycle on the
// slave side; a byte that closes a hex or octal run and is not itself a backslash
// makes two results, which the output side sends one after the other.
// Classification runs in a front stage, results wait in a four-entry queue, and
// an output register drives the master side, so the byte stream keeps flowing
// at one transaction per cycle as long as the results average one per cycle;
// in_tready falls only while that queue is full. Each result passes through the
// queue and then the output register. in_tlast marks an end-of-stream
// transaction whose data is ignored and which flushes any pending escape;
// out_tlast marks the last result of each input transaction.
module escape_sequence_decoder_core import esd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  wire logic              in_tlast,   // end_of_stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [CHAR_W-1:0]      out_tdata,  // [15:0] char_value
  output logic [2:0]             out_tuser,  // [1:0] warn_code, [2] dangling_escape
  output logic                   out_tlast   // last_of_run
);

  logic   accept;
  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;
  qstat_t stat;
  res_t   out_res;

  assign in_tready = !stat.full;
  assign accept = in_tvalid && in_tready;

  esd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_eos  (in_tlast),
    .push    (push),
    .cmd     (push_cmd)
  );

  esd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  esd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = {out_res.dangling, out_res.warn};
  assign out_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== tb/sv/escape_sequence_decoder_core_tb.sv =====
`default_nettype none
module escape_sequence_decoder_core_tb;
  import esd_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SCRIPT_LEN = 27;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       known;
    res_t       want;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Decoder state as the predictor sees it
  mode_t       dec_mode;
  logic [15:0] run_value;

  res_t        expected_chars[$];
  res_t        head;
  logic        steady;
  int          err_count;
  int          cycle_count;
  int          items_sent;
  int          chars_checked;
  int          flush_count;
  int          hex_runs;
  int          oct_runs;
  int          double_items;

  string       hex_chars = "0123456789abcdefABCDEF";
  string       esc_letters = "avntrbf";

  escape_sequence_decoder_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic res_t make_char(input logic [15:0] v, input logic [1:0] w,
                                     input logic dang);
    res_t r;
    r.value = v;
    r.warn = w;
    r.dangling = dang;
    r.last = 1'b0;
    return r;
  endfunction

  // -1 for a byte that is not a hex digit
  function automatic int hex_weight(input logic [7:0] b);
    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) return int'(b - CH_DIGIT_0);
    if (b >= CH_LOWER_A && b <= CH_LOWER_F) return int'(b - CH_LOWER_A) + 10;
    if (b >= CH_UPPER_A && b <= CH_UPPER_F) return int'(b - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] control_code(input logic [7:0] b);
    case (b)
      CH_LOWER_A: return CODE_BEL;
      CH_LOWER_V: return CODE_VT;
      CH_LOWER_N: return CODE_LF;
      CH_LOWER_T: return CODE_HT;
      CH_LOWER_R: return CODE_CR;
      CH_LOWER_B: return CODE_BS;
      CH_LOWER_F: return CODE_FF;
      default:    return b;
    endcase
  endfunction

  task automatic decode_transaction(input logic [7:0] b, input logic eos,
                                    output res_t outs[$]);
    int   d;
    logic replay;
    outs = {};
    replay = 1'b0;
    if (eos) begin
      flush_count++;
      case (dec_mode)
        MODE_ESC:       outs.push_back(make_char({8'h00, CH_BACKSLASH}, WARN_NONE, 1'b1));
        MODE_HEX_FIRST: outs.push_back(make_char({8'h00, CH_LOWER_X}, WARN_HEX, 1'b0));
        MODE_HEX_RUN:   outs.push_back(make_char(run_value, WARN_HEX, 1'b0));
        MODE_OCT_RUN:   outs.push_back(make_char(run_value, WARN_NONE, 1'b0));
        default: ;
      endcase
      dec_mode = MODE_PLAIN;
      run_value = '0;
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          dec_mode = MODE_PLAIN;
          if (b == CH_LOWER_X) begin
            dec_mode = MODE_HEX_FIRST;
            run_value = '0;
            hex_runs++;
          end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_7) begin
            dec_mode = MODE_OCT_RUN;
            run_value = 16'(b - CH_DIGIT_0);
            oct_runs++;
          end else begin
            outs.push_back(make_char({8'h00, control_code(b)},
                                     (b == CH_LOWER_A) ? WARN_ALERT : WARN_NONE, 1'b0));
          end
        end
        MODE_HEX_FIRST, MODE_HEX_RUN: begin
          d = hex_weight(b);
          if (d >= 0) begin
            run_value = (run_value << 4) | 16'(d);
            dec_mode = MODE_HEX_RUN;
          end else begin
            outs.push_back(make_char((dec_mode == MODE_HEX_FIRST) ? {8'h00, CH_LOWER_X}
                                                                  : run_value,
                                     WARN_HEX, 1'b0));
            run_value = '0;
            replay = 1'b1;
          end
        end
        MODE_OCT_RUN: begin
          if (b >= CH_DIGIT_0 && b <= CH_DIGIT_7) begin
            run_value = (run_value << 3) | 16'(b - CH_DIGIT_0);
          end else begin
            outs.push_back(make_char(run_value, WARN_NONE, 1'b0));
            run_value = '0;
            replay = 1'b1;
          end
        end
        default: replay = 1'b1;
      endcase
      // the byte that ends a run is decoded again as a plain byte
      if (replay) begin
        if (b == CH_BACKSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          dec_mode = MODE_PLAIN;
          outs.push_back(make_char({8'h00, b}, WARN_NONE, 1'b0));
        end
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    if (outs.size() > 1) double_items++;
  endtask

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", what);
  endtask

  task automatic send(input logic [7:0] b, input logic eos, input logic known = 1'b0,
                      input res_t want = '0);
    res_t outs[$];
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    decode_transaction(b, eos, outs);
    if (known) begin
      expected_chars.push_back(want);
    end else begin
      foreach (outs[i]) expected_chars.push_back(outs[i]);
    end
    items_sent++;
  endtask

  // Hold the sender until every pending character has come out
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic close_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) send(8'($urandom), 1'b0);
    else if (r < 80) send(CH_BACKSLASH, 1'b0);
    else send(8'($urandom), 1'b1);
  endtask

  task automatic random_sequence();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send(8'($urandom), 1'b0);
    end else if (r < 40) begin
      send(CH_BACKSLASH, 1'b0);
      if ($urandom_range(0, 9) < 7)
        send(esc_letters[$urandom_range(0, esc_letters.len()-1)], 1'b0);
      else
        send(8'($urandom), 1'b0);
    end else if (r < 60) begin
      send(CH_BACKSLASH, 1'b0);
      send(CH_LOWER_X, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send(hex_chars[$urandom_range(0, hex_chars.len()-1)], 1'b0);
      close_run();
    end else if (r < 80) begin
      send(CH_BACKSLASH, 1'b0);
      n = $urandom_range(0, 7);
      repeat (n + 1) send(CH_DIGIT_0 + 8'($urandom_range(0, 7)), 1'b0);
      close_run();
    end else if (r < 88) begin
      send(CH_BACKSLASH, 1'b0);
      if ($urandom_range(0, 1)) send(8'($urandom), 1'b1);
      else send(CH_BACKSLASH, 1'b0);
    end else begin
      send(8'($urandom), ($urandom_range(0, 9) < 3));
    end
  endtask

  // Directed opening: extremes, control escapes, long runs that wrap, flushes
  script_row_t script [SCRIPT_LEN] = '{
    '{8'hFF,        1'b1, 1'b0, '0},
    '{8'h00,        1'b0, 1'b1, '{16'h0000, WARN_NONE, 1'b0, 1'b1}},
    '{8'hFF,        1'b0, 1'b1, '{16'h00FF, WARN_NONE, 1'b0, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_LOWER_A,   1'b0, 1'b1, '{16'h0007, WARN_ALERT, 1'b0, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_LOWER_F,   1'b0, 1'b1, '{16'h000C, WARN_NONE, 1'b0, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_LOWER_X,   1'b0, 1'b0, '0},
    '{8'h31,        1'b0, 1'b0, '0},
    '{CH_UPPER_A,   1'b0, 1'b0, '0},
    '{CH_LOWER_B,   1'b0, 1'b0, '0},
    '{8'h63,        1'b0, 1'b0, '0},
    '{CH_LOWER_F,   1'b0, 1'b0, '0},
    '{8'h47,        1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_LOWER_X,   1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{CH_DIGIT_7,   1'b0, 1'b0, '0},
    '{8'h38,        1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},
    '{8'hA5,        1'b1, 1'b1, '{16'h005C, WARN_NONE, 1'b1, 1'b1}}
  };

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("unexpected char %04h tuser %03b last %b",
                             out_tdata, out_tuser, out_tlast));
      end else begin
        head = expected_chars.pop_front();
        if (out_tdata !== head.value || out_tuser[1:0] !== head.warn ||
            out_tuser[2] !== head.dangling || out_tlast !== head.last)
          flag_error($sformatf(
            "char %0d: expected %04h warn %0d dangling %b last %b, got %04h %0d %b %b",
            chars_checked, head.value, head.warn, head.dangling, head.last,
            out_tdata, out_tuser[1:0], out_tuser[2], out_tlast));
        chars_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d chars still pending",
               cycle_count, expected_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    steady = 1'b0;
    dec_mode = MODE_PLAIN;
    run_value = '0;
    err_count = 0;
    cycle_count = 0;
    items_sent = 0;
    chars_checked = 0;
    flush_count = 0;
    hex_runs = 0;
    oct_runs = 0;
    double_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send(script[i].b, script[i].eos, script[i].known, script[i].want);
    wait_for_drain();

    while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
      // no idling on either side through the middle of the random part
      steady = (items_sent >= SCRIPT_LEN + 300) && (items_sent < SCRIPT_LEN + 450);
      random_sequence();
    end
    steady = 1'b0;

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d end-of-stream), checked %0d chars, %0d mismatches",
             items_sent, flush_count, chars_checked, err_count);
    $display("Covered %0d hex runs, %0d octal runs, %0d transactions with two chars",
             hex_runs, oct_runs, double_items);
    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/esd_pkg.sv
rtl/esd_front.sv
rtl/esd_queue.sv
rtl/esd_back.sv
rtl/escape_sequence_decoder_core.sv
tb/sv/escape_sequence_decoder_core_tb.sv
